// File: rtl/spimb_pkg.sv
// Shared types, divider constants and helpers for the SPI mode and baud select block.
`timescale 1ns / 1ps

package spimb_pkg;

  localparam int CLOCK_W = 27;
  localparam int RATE_W  = 26;
  localparam int BAUD_W  = 7;
  localparam int PRE_W   = 3;
  localparam int SHIFT_W = 4;
  localparam int PROD_W  = 53;

  // Reset value of the core clock register
  localparam logic [CLOCK_W-1:0] CORE_CLOCK_RESET = 27'd20971520;

  // Exact reciprocal multipliers for 26-bit dividends: floor(x / d) = (x * M) >> K
  localparam logic [26:0] MULT_DIV3  = 27'd89478486;
  localparam int          SHIFT_DIV3 = 28;
  localparam logic [26:0] MULT_DIV5  = 27'd107374183;
  localparam int          SHIFT_DIV5 = 29;
  localparam logic [26:0] MULT_DIV7  = 27'd76695845;
  localparam int          SHIFT_DIV7 = 29;

  // Largest legal request codes
  localparam logic [2:0] MODE_MAX = 3'd3;
  localparam logic [1:0] SIDE_MAX = 2'd1;

  typedef struct packed {
    logic              err;
    logic              mst;
    logic              pol;
    logic              pha;
    logic [RATE_W-1:0] target;
  } meta_t;

  typedef struct packed {
    logic              valid;
    logic [RATE_W-1:0] diff;
    logic [RATE_W-1:0] rate;
    logic [BAUD_W-1:0] baud;
  } cand_t;

  // floor(x / p) for prescaler p in 1..8; at most one constant multiply
  function automatic logic [RATE_W-1:0] div_by_prescaler(input logic [RATE_W-1:0] x,
                                                         input logic [3:0] p);
    logic [PROD_W-1:0] prod;
    logic [RATE_W-1:0] res;
    begin
      prod = '0;
      res  = x;
      unique case (p)
        4'd2: res = x >> 1;
        4'd3: begin
          prod = PROD_W'(x) * PROD_W'(MULT_DIV3);
          res  = RATE_W'(prod >> SHIFT_DIV3);
        end
        4'd4: res = x >> 2;
        4'd5: begin
          prod = PROD_W'(x) * PROD_W'(MULT_DIV5);
          res  = RATE_W'(prod >> SHIFT_DIV5);
        end
        4'd6: begin
          prod = PROD_W'(x >> 1) * PROD_W'(MULT_DIV3);
          res  = RATE_W'(prod >> SHIFT_DIV3);
        end
        4'd7: begin
          prod = PROD_W'(x) * PROD_W'(MULT_DIV7);
          res  = RATE_W'(prod >> SHIFT_DIV7);
        end
        4'd8: res = x >> 3;
        default: res = x;
      endcase
      return res;
    end
  endfunction

  // Pick the better of two candidates; the left (earlier) one wins ties
  function automatic cand_t pick_best(input cand_t l, input cand_t r);
    begin
      if (r.valid && (!l.valid || (r.diff < l.diff))) begin
        return r;
      end
      return l;
    end
  endfunction

endpackage

// File: rtl/spi_mode_and_baud_select.sv
// Top level: pipelined SPI mode check and baud divider search.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid / in_stall) carries one request per transfer: SPI mode,
//   bus side and target bit rate. Output channel (out_valid / out_stall) returns one
//   result per request, in order: error flag, master/polarity/phase bits, packed baud
//   byte, achieved rate and absolute rate error.
//   Config channel (cfg_valid / cfg_ready) writes the core clock; cfg_ready is always
//   high. Write it only while no request is in flight.
// Pipeline and throughput
//   One request enters every cycle while the output is not stalled: the stages are input
//   register, constant-reciprocal divide by each prescaler, candidate rate and error
//   per (prescaler, shift), then one compare per min-tree level, then the output register.
// Reset
//   rst_n low clears all stage valid bits and loads the core clock reset value.
// Stall
//   Each stage holds while its successor is full and held; bubbles still close up
//   behind a stalled output, so in_stall rises only once every stage holds a request.
module spi_mode_and_baud_select #(
  parameter int PRESCALER_COUNT = 8,
  parameter int SHIFT_CODE_MAX  = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [26:0] cfg_core_clock_hz,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_spi_mode,
  input  logic [1:0]  in_bus_side,
  input  logic [25:0] in_target_rate_hz,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_config_error,
  output logic        out_master_bit,
  output logic        out_clock_polarity,
  output logic        out_clock_phase,
  output logic [6:0]  out_baud_byte,
  output logic [25:0] out_achieved_rate_hz,
  output logic [25:0] out_rate_error_hz
);

  localparam int NC    = PRESCALER_COUNT * (SHIFT_CODE_MAX + 1);
  localparam int LV    = (NC > 1) ? $clog2(NC) : 0;
  localparam int NLEAF = 1 << LV;
  localparam int NS    = LV + 4;
  localparam int ROOT  = NS - 2;
  localparam int RW    = spimb_pkg::RATE_W;

  // Core clock register
  logic [spimb_pkg::CLOCK_W-1:0] core_clock_r;

  // Per-stage valid bits and advance enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // Request sideband travels with every stage up to the tree root
  spimb_pkg::meta_t meta_r [0:ROOT];
  spimb_pkg::meta_t meta0_nxt;

  logic [RW-1:0] spi_clock_r;
  logic [RW-1:0] q_r   [0:PRESCALER_COUNT-1];
  logic [RW-1:0] q_nxt [0:PRESCALER_COUNT-1];

  // Candidate heap: leaves at NLEAF.., root at 1
  spimb_pkg::cand_t heap_r   [1:2*NLEAF-1];
  spimb_pkg::cand_t heap_nxt [1:2*NLEAF-1];

  logic                          out_valid_r;
  logic                          out_err_r;
  logic                          out_mst_r;
  logic                          out_pol_r;
  logic                          out_pha_r;
  logic [spimb_pkg::BAUD_W-1:0]  out_baud_r;
  logic [RW-1:0]                 out_rate_r;
  logic [RW-1:0]                 out_diff_r;

  // Configuration write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_clock_r <= spimb_pkg::CORE_CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      core_clock_r <= cfg_core_clock_hz;
    end
  end

  // Advance chain: a stage moves when it is empty or its successor moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 0: range check, split mode bits, take half the core clock
  always_comb begin
    meta0_nxt.err    = (in_spi_mode > spimb_pkg::MODE_MAX) || (in_bus_side > spimb_pkg::SIDE_MAX);
    meta0_nxt.mst    = in_bus_side[0];
    meta0_nxt.pol    = in_spi_mode[1];
    meta0_nxt.pha    = in_spi_mode[0];
    meta0_nxt.target = in_target_rate_hz;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      meta_r[0]   <= meta0_nxt;
      spi_clock_r <= RW'(core_clock_r >> 1);
    end
    for (int k = 1; k <= ROOT; k++) begin
      if (en[k]) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  // Stage 1: divide the SPI clock by each prescaler
  always_comb begin
    for (int p = 0; p < PRESCALER_COUNT; p++) begin
      q_nxt[p] = spimb_pkg::div_by_prescaler(spi_clock_r, 4'(p + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int p = 0; p < PRESCALER_COUNT; p++) begin
        q_r[p] <= q_nxt[p];
      end
    end
  end

  // Stage 2: one leaf per (prescaler, shift) in search order; pad leaves are invalid
  for (genvar gj = 0; gj < NLEAF; gj++) begin : g_leaf
    if (gj < NC) begin : g_real
      localparam int GP = gj / (SHIFT_CODE_MAX + 1);
      localparam int GS = gj % (SHIFT_CODE_MAX + 1);
      logic [RW-1:0] rate;
      always_comb begin
        rate = q_r[GP] >> (GS + 1);
        heap_nxt[NLEAF+gj].valid = 1'b1;
        heap_nxt[NLEAF+gj].rate  = rate;
        heap_nxt[NLEAF+gj].diff  = (rate > meta_r[1].target) ? (rate - meta_r[1].target)
                                                              : (meta_r[1].target - rate);
        heap_nxt[NLEAF+gj].baud  = {spimb_pkg::PRE_W'(GP), spimb_pkg::SHIFT_W'(GS)};
      end
    end else begin : g_pad
      assign heap_nxt[NLEAF+gj] = '0;
    end
    always_ff @(posedge clk) begin
      if (en[2]) begin
        heap_r[NLEAF+gj] <= heap_nxt[NLEAF+gj];
      end
    end
  end

  // Min tree: one registered compare per level, earlier candidate wins ties
  for (genvar gi = 1; gi < NLEAF; gi++) begin : g_node
    localparam int DEPTH = $clog2(gi + 1) - 1;
    localparam int STG   = 2 + LV - DEPTH;
    assign heap_nxt[gi] = spimb_pkg::pick_best(heap_r[2*gi], heap_r[2*gi+1]);
    always_ff @(posedge clk) begin
      if (en[STG]) begin
        heap_r[gi] <= heap_nxt[gi];
      end
    end
  end

  // Output register: zero everything but the flag on a bad request
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_err_r <= meta_r[ROOT].err;
      if (meta_r[ROOT].err) begin
        out_mst_r  <= 1'b0;
        out_pol_r  <= 1'b0;
        out_pha_r  <= 1'b0;
        out_baud_r <= '0;
        out_rate_r <= '0;
        out_diff_r <= '0;
      end else begin
        out_mst_r  <= meta_r[ROOT].mst;
        out_pol_r  <= meta_r[ROOT].pol;
        out_pha_r  <= meta_r[ROOT].pha;
        out_baud_r <= heap_r[1].baud;
        out_rate_r <= heap_r[1].rate;
        out_diff_r <= heap_r[1].diff;
      end
    end
  end

  assign out_valid_r          = v_r[NS-1];
  assign out_valid            = out_valid_r;
  assign out_config_error     = out_err_r;
  assign out_master_bit       = out_mst_r;
  assign out_clock_polarity   = out_pol_r;
  assign out_clock_phase      = out_pha_r;
  assign out_baud_byte        = out_baud_r;
  assign out_achieved_rate_hz = out_rate_r;
  assign out_rate_error_hz    = out_diff_r;

  // An error result carries nothing but the flag
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_config_error) |->
      (out_baud_byte == '0 && out_achieved_rate_hz == '0 && out_rate_error_hz == '0 &&
       !out_master_bit && !out_clock_polarity && !out_clock_phase))
    else $error("error result with nonzero fields");

  // The chosen divider stays inside the searched range
  a_baud_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_config_error) |->
      (32'(out_baud_byte[3:0]) <= SHIFT_CODE_MAX && 32'(out_baud_byte[6:4]) < PRESCALER_COUNT))
    else $error("baud byte outside search range");

  // With no result waiting, the input side is never held off
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // Input is held off only when the first stage and the output are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r[0] && out_valid))
    else $error("input stalled with room in the pipeline");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule
